// ----- rtl/core/nfba_pkg.sv -----
// ----------------------------------------------------------------------------
// nfba_pkg
// Shared widths, codes and types of the next-fit bitmap page allocator.
// ----------------------------------------------------------------------------
package nfba_pkg;

    // Bitmap word: pages scanned together in one step
    localparam int WORD_BITS = 32;
    localparam int WB        = 5;

    // Field and register widths
    localparam int NUM_PAGES_W = 11;
    localparam int RSV_W       = 10;
    localparam int PAGE_W      = 10;
    localparam int STATUS_W    = 2;

    // Register reset values
    localparam logic [NUM_PAGES_W-1:0] NUM_PAGES_RST = NUM_PAGES_W'(1024);
    localparam logic [RSV_W-1:0]       RSV_RST       = RSV_W'(1);

    // Register indexes
    localparam logic CFG_NUM_PAGES      = 1'b0;
    localparam logic CFG_RESERVED_PAGES = 1'b1;

    // Request kinds
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_PAGE  = 2'd3;

    // Answer of the word scan unit
    typedef struct packed {
        logic          hit;
        logic [WB-1:0] idx;
    } scan_res_t;

endpackage

// ----- rtl/core/next_fit_bitmap_page_allocator_top.sv -----
// ----------------------------------------------------------------------------
// next_fit_bitmap_page_allocator_top
// Next-fit page allocator over a one-bit-per-page used bitmap.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   func, page                     word taken when start & !busy
//  result    page_out, status               done high for one cycle
//  config    cfg_addr, cfg_wdata            written when cfg_we is high
//
//  Allocate: one 32-page bitmap word is visited per cycle; the next-fit
//  search visits at most 2*max(1, ceil(n/32)) words (cursor to end, then
//  from page 0). Free reads one bitmap word and clears the page's bit if
//  set; a reserved or out-of-range page is answered without a bitmap read.
//  The single bitmap read port sets the pace.
//  After reset the bitmap is cleared one word per cycle with busy high;
//  config writes are taken throughout.
//  done is a one-cycle strobe; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module next_fit_bitmap_page_allocator_top
    import nfba_pkg::*;
#(
    parameter int PAGES = 1024
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   func,
    input  logic [PAGE_W-1:0]      page,
    output logic                   done,
    output logic [PAGE_W-1:0]      page_out,
    output logic [STATUS_W-1:0]    status,
    input  logic                   cfg_we,
    input  logic                   cfg_addr,
    input  logic [NUM_PAGES_W-1:0] cfg_wdata
);

    // Largest usable pool: bounded by storage and by the page count register
    localparam int NREG_MAX = (1 << NUM_PAGES_W) - 1;
    localparam int NMAX     = (PAGES < NREG_MAX) ? PAGES : NREG_MAX;
    localparam int IW       = (NMAX > 1) ? $clog2(NMAX) : 1;
    localparam int DEPTH    = (PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW       = AW + WB;
    localparam int CW       = ((XW > NUM_PAGES_W) ? XW : NUM_PAGES_W) + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CLEAR = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_FREE  = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [AW-1:0]          ptr_reg, ptr_next;
    logic                   phase_reg, phase_next;
    logic [CW-1:0]          lo_reg, lo_next;
    logic [PAGE_W-1:0]      page_reg, page_next;
    logic [IW-1:0]          cursor_reg, cursor_next;
    logic [NUM_PAGES_W-1:0] num_pages_reg;
    logic [RSV_W-1:0]       reserved_pages_reg;
    logic                   done_reg, done_next;
    logic [PAGE_W-1:0]      page_out_reg, page_out_next;
    logic [STATUS_W-1:0]    status_reg, status_next;

    logic                   ram_we;
    logic [WORD_BITS-1:0]   ram_wdata;
    logic [WORD_BITS-1:0]   ram_rdata;

    logic [CW-1:0]          n_w;
    logic [CW-1:0]          rc_w;
    logic [CW-1:0]          cur_w;
    logic [CW-1:0]          start_w;
    logic [CW-1:0]          page_w;
    logic [CW-1:0]          base_w;
    logic [CW-1:0]          found_w;
    logic [CW-1:0]          found_inc;
    logic [CW-1:0]          free_word;
    logic [CW-1:0]          start_word;
    logic                   last_word;
    logic [WORD_BITS-1:0]   bit_sel;
    scan_res_t              scan;

    // Effective pool size and reserved count
    always_comb
    begin
        if (num_pages_reg > NUM_PAGES_W'(NMAX))
            n_w = CW'(NMAX);
        else
            n_w = CW'(num_pages_reg);

        // page 0 is the full marker, so it is always reserved
        if (reserved_pages_reg == '0)
            rc_w = CW'(1);
        else
            rc_w = CW'(reserved_pages_reg);

        cur_w      = CW'(cursor_reg);
        start_w    = (cur_w < n_w) ? cur_w : '0;
        page_w     = CW'(page);
        start_word = start_w >> WB;
        free_word  = page_w >> WB;

        base_w     = CW'({ptr_reg, {WB{1'b0}}});
        found_w    = CW'({ptr_reg, scan.idx});
        found_inc  = found_w + CW'(1);
        last_word  = (base_w + CW'(WORD_BITS)) >= n_w;
    end

    nfba_scan_unit #(
        .CW (CW)
    ) u_scan (
        .word (ram_rdata),
        .base (base_w),
        .lo   (lo_reg),
        .hi   (n_w),
        .res  (scan)
    );

    // Bitmap: the read address follows ptr_next so the word for ptr_reg
    // is on ram_rdata in the cycle that checks it
    nfba_map_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (ram_wdata),
        .raddr (ptr_next),
        .rdata (ram_rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        phase_next    = phase_reg;
        lo_next       = lo_reg;
        page_next     = page_reg;
        cursor_next   = cursor_reg;
        done_next     = 1'b0;
        page_out_next = page_out_reg;
        status_next   = status_reg;
        ram_we        = 1'b0;
        ram_wdata     = ram_rdata;
        bit_sel       = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // wipe one word per cycle after reset
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (ptr_reg == AW'(DEPTH - 1))
                    state_next = S_IDLE;
                else
                    ptr_next = ptr_reg + AW'(1);
            end

            S_IDLE:
            begin
                if (start)
                begin
                    page_next = page;
                    if (func == FUNC_ALLOC)
                    begin
                        // first pass: cursor (or 0) to end of pool
                        lo_next    = (start_w > rc_w) ? start_w : rc_w;
                        ptr_next   = start_word[AW-1:0];
                        phase_next = 1'b0;
                        state_next = S_SCAN;
                    end
                    else if (page_w >= n_w || page_w < rc_w)
                    begin
                        // reserved or out of range: answer at once
                        done_next     = 1'b1;
                        page_out_next = '0;
                        status_next   = ST_BAD_PAGE;
                    end
                    else
                    begin
                        ptr_next   = free_word[AW-1:0];
                        state_next = S_FREE;
                    end
                end
            end

            S_SCAN:
            begin
                if (scan.hit)
                begin
                    bit_sel       = WORD_BITS'(1) << scan.idx;
                    ram_we        = 1'b1;
                    ram_wdata     = ram_rdata | bit_sel;
                    cursor_next   = (found_inc >= n_w) ? '0 : found_inc[IW-1:0];
                    done_next     = 1'b1;
                    page_out_next = found_w[PAGE_W-1:0];
                    status_next   = ST_OK;
                    state_next    = S_IDLE;
                end
                else if (last_word)
                begin
                    if (!phase_reg)
                    begin
                        // wrap: second pass over the whole pool
                        phase_next = 1'b1;
                        lo_next    = rc_w;
                        ptr_next   = '0;
                    end
                    else
                    begin
                        done_next     = 1'b1;
                        page_out_next = '0;
                        status_next   = ST_FULL;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end

            S_FREE:
            begin
                bit_sel       = WORD_BITS'(1) << page_reg[WB-1:0];
                done_next     = 1'b1;
                page_out_next = '0;
                state_next    = S_IDLE;
                if ((ram_rdata & bit_sel) == '0)
                begin
                    status_next = ST_NOT_ALLOC;
                end
                else
                begin
                    ram_we      = 1'b1;
                    ram_wdata   = ram_rdata & ~bit_sel;
                    status_next = ST_OK;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            ptr_reg      <= '0;
            phase_reg    <= 1'b0;
            cursor_reg   <= '0;
            done_reg     <= 1'b0;
            page_out_reg <= '0;
            status_reg   <= ST_OK;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            phase_reg    <= phase_next;
            cursor_reg   <= cursor_next;
            done_reg     <= done_next;
            page_out_reg <= page_out_next;
            status_reg   <= status_next;
        end
    end

    // Request payload and scan window, no reset needed
    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        page_reg <= page_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_pages_reg      <= NUM_PAGES_RST;
            reserved_pages_reg <= RSV_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_NUM_PAGES:      num_pages_reg      <= cfg_wdata;
                CFG_RESERVED_PAGES: reserved_pages_reg <= cfg_wdata[RSV_W-1:0];
            endcase
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign page_out = page_out_reg;
    assign status   = status_reg;

endmodule

// ----- rtl/core/nfba_map_ram.sv -----
// ----------------------------------------------------------------------------
// nfba_map_ram
// Used-mark bitmap storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nfba_map_ram
    import nfba_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WORD_BITS-1:0] wdata,
    input  logic [AW-1:0]        raddr,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/nfba_scan_unit.sv -----
// ----------------------------------------------------------------------------
// nfba_scan_unit
// Find the lowest free page of one bitmap word inside the window [lo, hi).
// ----------------------------------------------------------------------------
module nfba_scan_unit
    import nfba_pkg::*;
#(
    parameter int CW = 12
)
(
    input  logic [WORD_BITS-1:0] word,
    input  logic [CW-1:0]        base,
    input  logic [CW-1:0]        lo,
    input  logic [CW-1:0]        hi,
    output scan_res_t            res
);

    localparam logic [CW-1:0] SPAN = CW'(WORD_BITS);

    logic [CW-1:0]        lo_d;
    logic [CW-1:0]        hi_d;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] cand;

    always_comb
    begin
        lo_d = lo - base;
        hi_d = hi - base;

        // pages at or above lo
        if (lo <= base)
            lo_mask = '1;
        else if (lo_d >= SPAN)
            lo_mask = '0;
        else
            lo_mask = {WORD_BITS{1'b1}} << lo_d[WB-1:0];

        // pages below hi
        if (hi <= base)
            hi_mask = '0;
        else if (hi_d >= SPAN)
            hi_mask = '1;
        else
            hi_mask = ~({WORD_BITS{1'b1}} << hi_d[WB-1:0]);

        cand = ~word & lo_mask & hi_mask;

        // lowest set bit wins
        res.hit = |cand;
        res.idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (cand[i])
                res.idx = WB'(i);
        end
    end

endmodule
